FILE: rtl/core/wmrd_pkg.sv
package wmrd_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int MAX_CHANNELS   = 8;
    localparam int MAX_BINS       = 4096;
    localparam int MAX_BIN_FRAMES = 1048576;

    localparam int CH_W      = 4;
    localparam int SPB_W     = 21;
    localparam int BINS_W    = 13;
    localparam int CFG_W     = 21;
    localparam int CFG_IDX_W = 2;

    localparam int FSUM_W = SAMPLE_BITS + $clog2(MAX_CHANNELS);
    localparam int MAG_W  = FSUM_W;
    localparam int VAL_W  = FSUM_W;
    localparam int SQ_W   = 2 * MAG_W - 1;
    localparam int FRM_W  = SPB_W;
    localparam int SSUM_W = SQ_W + FRM_W - 1;
    localparam int DQ_W   = SQ_W;
    localparam int REM_W  = FRM_W;
    localparam int ROOT_W = (SQ_W + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int SREM_W = ROOT_W + 2;
    localparam int POS_W  = $clog2(MAX_CHANNELS) + 1;

    localparam int MIN_W = 16;
    localparam int MAX_W = 15;
    localparam int RMS_W = 16;
    localparam int BNR_W = 12;

    localparam int STEP_W = 4;
    localparam int CNT_W  = 6;

    localparam int CDIV_ITERS = MAG_W;
    localparam int MDIV_ITERS = DQ_W;
    localparam int SQRT_ITERS = ROOT_W;

    typedef logic [CH_W-1:0]      chan_t;
    typedef logic [SPB_W-1:0]     spb_t;
    typedef logic [BINS_W-1:0]    bins_t;
    typedef logic [CFG_W-1:0]     cfg_data_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [STEP_W-1:0]    step_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    localparam cfg_idx_t CFG_CHANNELS = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_SPB      = cfg_idx_t'(1);
    localparam cfg_idx_t CFG_BINS     = cfg_idx_t'(2);

    localparam chan_t CH_RESET   = chan_t'(1);
    localparam spb_t  SPB_RESET  = spb_t'(1);
    localparam bins_t BINS_RESET = bins_t'(1024);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCUM,
        OP_CDIV_LOAD,
        OP_DIV_STEP,
        OP_FRAME,
        OP_SQACC,
        OP_MDIV_LOAD,
        OP_SQRT_LOAD,
        OP_SQRT_STEP,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GO,
        J_IN,
        J_FRAME,
        J_LOOP,
        J_BIN,
        J_OUT
    } jmp_t;

    typedef struct packed {
        op_t   op;
        logic  take;
        jmp_t  jmp;
        step_t target;
        cnt_t  cnt;
    } ctl_t;

    typedef struct packed {
        logic fire;
        logic out_free;
        logic skip;
        logic frame_close;
        logic bin_close;
    } stat_t;

    typedef struct packed {
        logic div_load;
        logic div_step;
        logic sqrt_load;
        logic sqrt_step;
    } arith_ctl_t;

    typedef struct packed {
        logic signed [MIN_W-1:0] min_value;
        logic [MAX_W-1:0]        max_value;
        logic [RMS_W-1:0]        rms_value;
        logic [BNR_W-1:0]        bin_number;
    } res_t;

endpackage

FILE: rtl/core/wmrd_arith.sv
module wmrd_arith (
    input  logic                           clk,
    input  wmrd_pkg::arith_ctl_t           actl,
    input  logic [wmrd_pkg::REM_W-1:0]     ld_rem,
    input  logic [wmrd_pkg::DQ_W-1:0]      ld_dq,
    input  logic [wmrd_pkg::REM_W-1:0]     ld_divisor,
    output logic [wmrd_pkg::DQ_W-1:0]      quo,
    output logic [wmrd_pkg::ROOT_W-1:0]    root
);

    logic [wmrd_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [wmrd_pkg::DQ_W-1:0]     dq_reg, dq_next;
    logic [wmrd_pkg::REM_W-1:0]    dvs_reg, dvs_next;
    logic [wmrd_pkg::REM_W:0]      rem_sh;
    logic [wmrd_pkg::REM_W:0]      rem_diff;

    logic [wmrd_pkg::RAD_W-1:0]    sx_reg, sx_next;
    logic [wmrd_pkg::SREM_W-1:0]   srem_reg, srem_next;
    logic [wmrd_pkg::ROOT_W-1:0]   root_reg, root_next;
    logic [wmrd_pkg::SREM_W+1:0]   srem_sh;
    logic [wmrd_pkg::SREM_W+1:0]   trial;
    logic [wmrd_pkg::SREM_W+1:0]   srem_diff;

    // Restoring divider: one quotient bit per cycle.
    always_comb
    begin
        rem_sh   = {rem_reg, dq_reg[wmrd_pkg::DQ_W-1]};
        rem_diff = rem_sh - {1'b0, dvs_reg};
        rem_next = rem_reg;
        dq_next  = dq_reg;
        dvs_next = dvs_reg;
        if (actl.div_load)
        begin
            rem_next = ld_rem;
            dq_next  = ld_dq;
            dvs_next = ld_divisor;
        end
        else if (actl.div_step)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_diff[wmrd_pkg::REM_W-1:0];
                dq_next  = {dq_reg[wmrd_pkg::DQ_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[wmrd_pkg::REM_W-1:0];
                dq_next  = {dq_reg[wmrd_pkg::DQ_W-2:0], 1'b0};
            end
        end
    end

    // Digit-by-digit square root: two radicand bits per cycle.
    always_comb
    begin
        srem_sh   = {srem_reg, sx_reg[wmrd_pkg::RAD_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        srem_diff = srem_sh - trial;
        sx_next   = sx_reg;
        srem_next = srem_reg;
        root_next = root_reg;
        if (actl.sqrt_load)
        begin
            sx_next   = {{(wmrd_pkg::RAD_W - wmrd_pkg::DQ_W){1'b0}}, dq_reg};
            srem_next = '0;
            root_next = '0;
        end
        else if (actl.sqrt_step)
        begin
            sx_next = {sx_reg[wmrd_pkg::RAD_W-3:0], 2'b00};
            if (srem_sh >= trial)
            begin
                srem_next = srem_diff[wmrd_pkg::SREM_W-1:0];
                root_next = {root_reg[wmrd_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                srem_next = srem_sh[wmrd_pkg::SREM_W-1:0];
                root_next = {root_reg[wmrd_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dq_reg   <= dq_next;
        dvs_reg  <= dvs_next;
        sx_reg   <= sx_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
    end

    assign quo  = dq_reg;
    assign root = root_reg;

endmodule

FILE: rtl/core/wmrd_seq.sv
module wmrd_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  wmrd_pkg::stat_t  stat,
    output wmrd_pkg::ctl_t   ctl
);

    localparam wmrd_pkg::step_t P_WAIT  = wmrd_pkg::step_t'(0);
    localparam wmrd_pkg::step_t P_FCHK  = wmrd_pkg::step_t'(1);
    localparam wmrd_pkg::step_t P_CDIV  = wmrd_pkg::step_t'(2);
    localparam wmrd_pkg::step_t P_FRAME = wmrd_pkg::step_t'(3);
    localparam wmrd_pkg::step_t P_SQACC = wmrd_pkg::step_t'(4);
    localparam wmrd_pkg::step_t P_BCHK  = wmrd_pkg::step_t'(5);
    localparam wmrd_pkg::step_t P_MDIV  = wmrd_pkg::step_t'(6);
    localparam wmrd_pkg::step_t P_SQLD  = wmrd_pkg::step_t'(7);
    localparam wmrd_pkg::step_t P_SQRT  = wmrd_pkg::step_t'(8);
    localparam wmrd_pkg::step_t P_EMIT  = wmrd_pkg::step_t'(9);

    localparam wmrd_pkg::cnt_t NO_CNT = wmrd_pkg::cnt_t'(0);
    localparam wmrd_pkg::cnt_t C_CDIV = wmrd_pkg::cnt_t'(wmrd_pkg::CDIV_ITERS);
    localparam wmrd_pkg::cnt_t C_MDIV = wmrd_pkg::cnt_t'(wmrd_pkg::MDIV_ITERS);
    localparam wmrd_pkg::cnt_t C_SQRT = wmrd_pkg::cnt_t'(wmrd_pkg::SQRT_ITERS);
    localparam wmrd_pkg::cnt_t C_LAST = wmrd_pkg::cnt_t'(1);

    function automatic wmrd_pkg::ctl_t rom(input wmrd_pkg::step_t a);
        wmrd_pkg::ctl_t w;
        unique case (a)
            P_WAIT:  w = '{wmrd_pkg::OP_ACCUM, 1'b1, wmrd_pkg::J_IN, P_WAIT, NO_CNT};
            P_FCHK:  w = '{wmrd_pkg::OP_CDIV_LOAD, 1'b0, wmrd_pkg::J_FRAME, P_BCHK, C_CDIV};
            P_CDIV:  w = '{wmrd_pkg::OP_DIV_STEP, 1'b0, wmrd_pkg::J_LOOP, P_WAIT, NO_CNT};
            P_FRAME: w = '{wmrd_pkg::OP_FRAME, 1'b0, wmrd_pkg::J_NEXT, P_WAIT, NO_CNT};
            P_SQACC: w = '{wmrd_pkg::OP_SQACC, 1'b0, wmrd_pkg::J_NEXT, P_WAIT, NO_CNT};
            P_BCHK:  w = '{wmrd_pkg::OP_MDIV_LOAD, 1'b0, wmrd_pkg::J_BIN, P_WAIT, C_MDIV};
            P_MDIV:  w = '{wmrd_pkg::OP_DIV_STEP, 1'b0, wmrd_pkg::J_LOOP, P_WAIT, NO_CNT};
            P_SQLD:  w = '{wmrd_pkg::OP_SQRT_LOAD, 1'b0, wmrd_pkg::J_NEXT, P_WAIT, C_SQRT};
            P_SQRT:  w = '{wmrd_pkg::OP_SQRT_STEP, 1'b0, wmrd_pkg::J_LOOP, P_WAIT, NO_CNT};
            P_EMIT:  w = '{wmrd_pkg::OP_EMIT, 1'b0, wmrd_pkg::J_OUT, P_WAIT, NO_CNT};
            default: w = '{wmrd_pkg::OP_NONE, 1'b0, wmrd_pkg::J_GO, P_WAIT, NO_CNT};
        endcase
        return w;
    endfunction

    wmrd_pkg::step_t step_reg, step_next;
    wmrd_pkg::cnt_t  cnt_reg, cnt_next;
    wmrd_pkg::ctl_t  w;

    always_comb
    begin
        w        = rom(step_reg);
        cnt_next = cnt_reg;
        if (w.cnt != NO_CNT)
        begin
            cnt_next = w.cnt;
        end
        else if (w.jmp == wmrd_pkg::J_LOOP)
        begin
            cnt_next = cnt_reg - 1'b1;
        end

        unique case (w.jmp)
            wmrd_pkg::J_NEXT:  step_next = step_reg + 1'b1;
            wmrd_pkg::J_GO:    step_next = w.target;
            wmrd_pkg::J_IN:    step_next = (stat.fire && !stat.skip) ? step_reg + 1'b1 : step_reg;
            wmrd_pkg::J_FRAME: step_next = stat.frame_close ? step_reg + 1'b1 : w.target;
            wmrd_pkg::J_LOOP:  step_next = (cnt_reg == C_LAST) ? step_reg + 1'b1 : step_reg;
            wmrd_pkg::J_BIN:   step_next = stat.bin_close ? step_reg + 1'b1 : w.target;
            wmrd_pkg::J_OUT:   step_next = stat.out_free ? w.target : step_reg;
            default:           step_next = P_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= P_WAIT;
            cnt_reg  <= NO_CNT;
        end
        else
        begin
            step_reg <= step_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign ctl = w;

endmodule

FILE: rtl/core/wmrd_dp.sv
module wmrd_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  wmrd_pkg::op_t                         op,
    input  logic                                  in_fire,
    input  logic                                  out_free,
    input  logic signed [wmrd_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                  end_of_data,
    input  logic                                  cfg_write,
    input  wmrd_pkg::cfg_idx_t                    cfg_index,
    input  wmrd_pkg::cfg_data_t                   cfg_data,
    output wmrd_pkg::stat_t                       stat,
    output logic                                  emit,
    output wmrd_pkg::res_t                        res
);

    wmrd_pkg::chan_t chans_reg;
    wmrd_pkg::spb_t  spb_reg;
    wmrd_pkg::bins_t bins_reg;
    wmrd_pkg::chan_t chans_eff;
    wmrd_pkg::spb_t  spb_eff;
    wmrd_pkg::bins_t bins_eff;

    logic signed [wmrd_pkg::FSUM_W-1:0] frame_sum_reg, frame_sum_next;
    logic [wmrd_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic signed [wmrd_pkg::VAL_W-1:0]  bin_min_reg, bin_min_next;
    logic signed [wmrd_pkg::VAL_W-1:0]  bin_max_reg, bin_max_next;
    logic [wmrd_pkg::SSUM_W-1:0]        square_sum_reg, square_sum_next;
    logic [wmrd_pkg::FRM_W-1:0]         frames_reg, frames_next;
    wmrd_pkg::bins_t                    bins_done_reg, bins_done_next;
    logic                               last_reg, last_next;
    logic                               neg_reg, neg_next;
    logic [wmrd_pkg::SQ_W-1:0]          sq_reg, sq_next;

    logic                               skip;
    logic                               fs_neg;
    logic [wmrd_pkg::MAG_W-1:0]         fs_mag;
    logic [wmrd_pkg::MAG_W-1:0]         q;
    logic signed [wmrd_pkg::VAL_W-1:0]  fval;
    logic [2*wmrd_pkg::MAG_W-1:0]       prod;

    wmrd_pkg::arith_ctl_t               actl;
    logic [wmrd_pkg::REM_W-1:0]         ld_rem;
    logic [wmrd_pkg::DQ_W-1:0]          ld_dq;
    logic [wmrd_pkg::REM_W-1:0]         ld_divisor;
    logic [wmrd_pkg::DQ_W-1:0]          quo;
    logic [wmrd_pkg::ROOT_W-1:0]        root;

    always_comb
    begin
        if (chans_reg == '0)
            chans_eff = wmrd_pkg::chan_t'(1);
        else if (chans_reg > wmrd_pkg::chan_t'(wmrd_pkg::MAX_CHANNELS))
            chans_eff = wmrd_pkg::chan_t'(wmrd_pkg::MAX_CHANNELS);
        else
            chans_eff = chans_reg;

        if (spb_reg == '0)
            spb_eff = wmrd_pkg::spb_t'(1);
        else if (spb_reg > wmrd_pkg::spb_t'(wmrd_pkg::MAX_BIN_FRAMES))
            spb_eff = wmrd_pkg::spb_t'(wmrd_pkg::MAX_BIN_FRAMES);
        else
            spb_eff = spb_reg;

        if (bins_reg == '0)
            bins_eff = wmrd_pkg::bins_t'(1);
        else if (bins_reg > wmrd_pkg::bins_t'(wmrd_pkg::MAX_BINS))
            bins_eff = wmrd_pkg::bins_t'(wmrd_pkg::MAX_BINS);
        else
            bins_eff = bins_reg;
    end

    assign skip = (bins_done_reg >= bins_eff);
    assign emit = (op == wmrd_pkg::OP_EMIT) && out_free;

    always_comb
    begin
        stat.fire        = in_fire;
        stat.out_free    = out_free;
        stat.skip        = skip;
        stat.frame_close = (pos_reg >= chans_eff) || last_reg;
        stat.bin_close   = (frames_reg >= spb_eff) || last_reg;
    end

    assign fs_neg = frame_sum_reg[wmrd_pkg::FSUM_W-1];
    assign fs_mag = fs_neg ? (~frame_sum_reg + 1'b1) : frame_sum_reg;
    assign q      = quo[wmrd_pkg::MAG_W-1:0];
    assign fval   = neg_reg ? (~q + 1'b1) : q;
    assign prod   = q * q;

    always_comb
    begin
        actl.div_load  = (op == wmrd_pkg::OP_CDIV_LOAD) || (op == wmrd_pkg::OP_MDIV_LOAD);
        actl.div_step  = (op == wmrd_pkg::OP_DIV_STEP);
        actl.sqrt_load = (op == wmrd_pkg::OP_SQRT_LOAD);
        actl.sqrt_step = (op == wmrd_pkg::OP_SQRT_STEP);
        if (op == wmrd_pkg::OP_MDIV_LOAD)
        begin
            ld_rem     = {{(wmrd_pkg::REM_W - (wmrd_pkg::SSUM_W - wmrd_pkg::DQ_W)){1'b0}},
                          square_sum_reg[wmrd_pkg::SSUM_W-1:wmrd_pkg::DQ_W]};
            ld_dq      = square_sum_reg[wmrd_pkg::DQ_W-1:0];
            ld_divisor = frames_reg;
        end
        else
        begin
            ld_rem     = '0;
            ld_dq      = {fs_mag, {(wmrd_pkg::DQ_W - wmrd_pkg::MAG_W){1'b0}}};
            ld_divisor = {{(wmrd_pkg::REM_W - wmrd_pkg::CH_W){1'b0}}, chans_eff};
        end
    end

    always_comb
    begin
        frame_sum_next  = frame_sum_reg;
        pos_next        = pos_reg;
        bin_min_next    = bin_min_reg;
        bin_max_next    = bin_max_reg;
        square_sum_next = square_sum_reg;
        frames_next     = frames_reg;
        bins_done_next  = bins_done_reg;
        last_next       = last_reg;
        neg_next        = neg_reg;
        sq_next         = sq_reg;

        unique case (op)
            wmrd_pkg::OP_ACCUM:
            begin
                if (in_fire)
                begin
                    if (skip)
                    begin
                        if (end_of_data)
                        begin
                            frame_sum_next  = '0;
                            pos_next        = '0;
                            bin_min_next    = '0;
                            bin_max_next    = '0;
                            square_sum_next = '0;
                            frames_next     = '0;
                            bins_done_next  = '0;
                        end
                    end
                    else
                    begin
                        frame_sum_next = frame_sum_reg
                            + {{(wmrd_pkg::FSUM_W - wmrd_pkg::SAMPLE_BITS)
                                {sample[wmrd_pkg::SAMPLE_BITS-1]}}, sample};
                        pos_next       = pos_reg + 1'b1;
                        last_next      = end_of_data;
                    end
                end
            end
            wmrd_pkg::OP_CDIV_LOAD:
            begin
                neg_next = fs_neg;
            end
            wmrd_pkg::OP_FRAME:
            begin
                if (fval < bin_min_reg)
                    bin_min_next = fval;
                if (fval > bin_max_reg)
                    bin_max_next = fval;
                sq_next        = prod[wmrd_pkg::SQ_W-1:0];
                frames_next    = frames_reg + 1'b1;
                frame_sum_next = '0;
                pos_next       = '0;
            end
            wmrd_pkg::OP_SQACC:
            begin
                square_sum_next = square_sum_reg
                    + {{(wmrd_pkg::SSUM_W - wmrd_pkg::SQ_W){1'b0}}, sq_reg};
            end
            wmrd_pkg::OP_EMIT:
            begin
                if (out_free)
                begin
                    bin_min_next    = '0;
                    bin_max_next    = '0;
                    square_sum_next = '0;
                    frames_next     = '0;
                    bins_done_next  = bins_done_reg + 1'b1;
                    if (last_reg)
                    begin
                        frame_sum_next = '0;
                        pos_next       = '0;
                        bins_done_next = '0;
                        last_next      = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chans_reg <= wmrd_pkg::CH_RESET;
            spb_reg   <= wmrd_pkg::SPB_RESET;
            bins_reg  <= wmrd_pkg::BINS_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == wmrd_pkg::CFG_CHANNELS)
                chans_reg <= cfg_data[wmrd_pkg::CH_W-1:0];
            else if (cfg_index == wmrd_pkg::CFG_SPB)
                spb_reg <= cfg_data[wmrd_pkg::SPB_W-1:0];
            else if (cfg_index == wmrd_pkg::CFG_BINS)
                bins_reg <= cfg_data[wmrd_pkg::BINS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_sum_reg  <= '0;
            pos_reg        <= '0;
            bin_min_reg    <= '0;
            bin_max_reg    <= '0;
            square_sum_reg <= '0;
            frames_reg     <= '0;
            bins_done_reg  <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            frame_sum_reg  <= frame_sum_next;
            pos_reg        <= pos_next;
            bin_min_reg    <= bin_min_next;
            bin_max_reg    <= bin_max_next;
            square_sum_reg <= square_sum_next;
            frames_reg     <= frames_next;
            bins_done_reg  <= bins_done_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        sq_reg  <= sq_next;
    end

    wmrd_arith u_arith (
        .clk        (clk),
        .actl       (actl),
        .ld_rem     (ld_rem),
        .ld_dq      (ld_dq),
        .ld_divisor (ld_divisor),
        .quo        (quo),
        .root       (root)
    );

    always_comb
    begin
        res.min_value  = bin_min_reg[wmrd_pkg::MIN_W-1:0];
        res.max_value  = bin_max_reg[wmrd_pkg::MAX_W-1:0];
        res.rms_value  = root[wmrd_pkg::RMS_W-1:0];
        res.bin_number = bins_done_reg[wmrd_pkg::BNR_W-1:0];
    end

endmodule

FILE: rtl/core/waveform_min_max_rms_decimator_core.sv
// Channel   Signals                                                  Dir
// input     in_valid, in_ready, sample, end_of_data                  in
// result    out_valid, out_ready, min_value, max_value, rms_value,   out
//           bin_number
// config    cfg_write, cfg_index, cfg_data                           in
//
// A sample that leaves its frame and bin open passes through take, frame check and bin check.
// A sample that closes a frame also runs the bit-serial channel divider (19 steps). A sample
// that closes a bin adds the 37-step mean divider and the 19-step square root loop of the
// shared arithmetic unit; a bin closed by a smaller bin size without a frame closing skips
// the channel divider.
// Reset is asynchronous and active low; it clears all stream state at once.
// A result waits in the output register while the next item is taken; the sequencer
// holds at its emit step only while an earlier result is still untaken.
module waveform_min_max_rms_decimator_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [wmrd_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                    end_of_data,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [wmrd_pkg::MIN_W-1:0]       min_value,
    output logic [wmrd_pkg::MAX_W-1:0]              max_value,
    output logic [wmrd_pkg::RMS_W-1:0]              rms_value,
    output logic [wmrd_pkg::BNR_W-1:0]              bin_number,
    input  logic                                    cfg_write,
    input  wmrd_pkg::cfg_idx_t                      cfg_index,
    input  wmrd_pkg::cfg_data_t                     cfg_data
);

    wmrd_pkg::ctl_t  ctl;
    wmrd_pkg::stat_t stat;
    wmrd_pkg::res_t  res;
    wmrd_pkg::res_t  res_reg;
    logic            out_valid_reg, out_valid_next;
    logic            in_fire;
    logic            out_free;
    logic            emit;

    assign in_ready = ctl.take;
    assign in_fire  = in_valid && ctl.take;
    assign out_free = !out_valid_reg || out_ready;

    wmrd_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    wmrd_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (ctl.op),
        .in_fire     (in_fire),
        .out_free    (out_free),
        .sample      (sample),
        .end_of_data (end_of_data),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .stat        (stat),
        .emit        (emit),
        .res         (res)
    );

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            res_reg <= res;
    end

    assign out_valid  = out_valid_reg;
    assign min_value  = res_reg.min_value;
    assign max_value  = res_reg.max_value;
    assign rms_value  = res_reg.rms_value;
    assign bin_number = res_reg.bin_number;

    a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || out_ready))
        else $error("result emitted over an untaken item");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("emitted result not presented");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(emit))
        else $error("output valid raised without an emit");

    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (ctl.op == wmrd_pkg::OP_ACCUM && !emit))
        else $error("input taken outside the wait step");

endmodule

FILE: tb/sv/wmrd_bin_checker.sv
module wmrd_bin_checker
    import wmrd_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          end_of_data,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic signed [MIN_W-1:0]       min_value,
    input  logic [MAX_W-1:0]              max_value,
    input  logic [RMS_W-1:0]              rms_value,
    input  logic [BNR_W-1:0]              bin_number,
    input  logic                          cfg_write,
    input  cfg_idx_t                      cfg_index,
    input  cfg_data_t                     cfg_data,
    output int                            fail_count,
    output int                            bins_waiting,
    output int                            live_items,
    output int                            ignored_items,
    output int                            bins_checked
);

    chan_t       chan_reg;
    spb_t        spb_reg;
    bins_t       bins_reg;
    int          frame_acc;
    int          chan_pos;
    int          lo_val;
    int          hi_val;
    logic [63:0] sq_acc;
    int          frames_acc;
    int          bins_made;
    res_t        pending_bins[$];
    res_t        next_bin;
    res_t        seen_bin;

    function automatic int eff_chans();
        if (chan_reg == 0) return 1;
        if (chan_reg > MAX_CHANNELS) return MAX_CHANNELS;
        return int'(chan_reg);
    endfunction

    function automatic int eff_frames();
        if (spb_reg == 0) return 1;
        if (spb_reg > MAX_BIN_FRAMES) return MAX_BIN_FRAMES;
        return int'(spb_reg);
    endfunction

    function automatic int eff_bins();
        if (bins_reg == 0) return 1;
        if (bins_reg > MAX_BINS) return MAX_BINS;
        return int'(bins_reg);
    endfunction

    function automatic logic [RMS_W-1:0] int_sqrt(input logic [63:0] v);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= v)
                root = trial;
        end
        return root[RMS_W-1:0];
    endfunction

    function automatic void reset_stream();
        frame_acc  = 0;
        chan_pos   = 0;
        lo_val     = 0;
        hi_val     = 0;
        sq_acc     = '0;
        frames_acc = 0;
        bins_made  = 0;
    endfunction

    // Folds one sample into the running frame and bin; returns 1 when a bin closes.
    function automatic bit fold_sample(input logic signed [SAMPLE_BITS-1:0] s,
                                       input logic eod, output res_t r);
        int          chans;
        int          frame_value;
        logic [63:0] mag;
        bit          made;
        made  = 0;
        r     = '0;
        chans = eff_chans();
        if (bins_made >= eff_bins()) begin
            ignored_items++;
            if (eod)
                reset_stream();
            return 0;
        end
        live_items++;
        frame_acc += int'(s);
        chan_pos++;
        if (chan_pos >= chans || eod) begin
            frame_value = frame_acc / chans;
            if (frame_value < lo_val)
                lo_val = frame_value;
            if (frame_value > hi_val)
                hi_val = frame_value;
            mag = 64'(frame_value < 0 ? -frame_value : frame_value);
            sq_acc += mag * mag;
            frames_acc++;
            frame_acc = 0;
            chan_pos  = 0;
        end
        if (frames_acc >= eff_frames() || (eod && frames_acc > 0)) begin
            r.min_value  = lo_val[MIN_W-1:0];
            r.max_value  = hi_val[MAX_W-1:0];
            r.rms_value  = int_sqrt(sq_acc / 64'(frames_acc));
            r.bin_number = bins_made[BNR_W-1:0];
            bins_made++;
            lo_val     = 0;
            hi_val     = 0;
            sq_acc     = '0;
            frames_acc = 0;
            made       = 1;
        end
        if (eod)
            reset_stream();
        return made;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg      = CH_RESET;
            spb_reg       = SPB_RESET;
            bins_reg      = BINS_RESET;
            reset_stream();
            pending_bins.delete();
            fail_count    = 0;
            bins_waiting  = 0;
            live_items    = 0;
            ignored_items = 0;
            bins_checked  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_bins.size() == 0)
                begin
                    $error("bin %0d delivered with no bin expected", bin_number);
                    fail_count++;
                end
                else
                begin
                    seen_bin = pending_bins.pop_front();
                    bins_checked++;
                    if (min_value !== seen_bin.min_value)
                    begin
                        $error("min_value: expected %0d, got %0d", seen_bin.min_value,
                               min_value);
                        fail_count++;
                    end
                    if (max_value !== seen_bin.max_value)
                    begin
                        $error("max_value: expected %0d, got %0d", seen_bin.max_value,
                               max_value);
                        fail_count++;
                    end
                    if (rms_value !== seen_bin.rms_value)
                    begin
                        $error("rms_value: expected %0d, got %0d", seen_bin.rms_value,
                               rms_value);
                        fail_count++;
                    end
                    if (bin_number !== seen_bin.bin_number)
                    begin
                        $error("bin_number: expected %0d, got %0d", seen_bin.bin_number,
                               bin_number);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (fold_sample(sample, end_of_data, next_bin))
                    pending_bins.push_back(next_bin);
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_CHANNELS: chan_reg = cfg_data[CH_W-1:0];
                    CFG_SPB:      spb_reg  = cfg_data[SPB_W-1:0];
                    CFG_BINS:     bins_reg = cfg_data[BINS_W-1:0];
                    default:      ;
                endcase
            end
            bins_waiting = pending_bins.size();
        end
    end

endmodule

FILE: tb/sv/tb_waveform_min_max_rms_decimator_core.sv
module tb_waveform_min_max_rms_decimator_core;

    import wmrd_pkg::*;

    localparam int ITEM_TARGET    = 1150;
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_data;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [MIN_W-1:0]       min_value;
    logic [MAX_W-1:0]              max_value;
    logic [RMS_W-1:0]              rms_value;
    logic [BNR_W-1:0]              bin_number;
    logic                          cfg_write;
    cfg_idx_t                      cfg_index;
    cfg_data_t                     cfg_data;

    int fail_count;
    int bins_waiting;
    int live_items;
    int ignored_items;
    int bins_checked;

    bit send_calm;
    bit recv_calm;
    bit hold_req;
    bit hold_served;
    int chan_now;
    int spb_now;
    int bins_now;
    int settings_used;
    int quiet_cycles;

    waveform_min_max_rms_decimator_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .end_of_data (end_of_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .min_value   (min_value),
        .max_value   (max_value),
        .rms_value   (rms_value),
        .bin_number  (bin_number),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    wmrd_bin_checker bin_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .end_of_data   (end_of_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .min_value     (min_value),
        .max_value     (max_value),
        .rms_value     (rms_value),
        .bin_number    (bin_number),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .bins_waiting  (bins_waiting),
        .live_items    (live_items),
        .ignored_items (ignored_items),
        .bins_checked  (bins_checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Bias 1 keeps every sample non-negative, bias 2 keeps every sample negative.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int bias);
        logic [SAMPLE_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2:       v = 16'(int'($urandom_range(0, 16)) - 8);
            3:       v = 16'h0000;
            default: v = 16'($urandom);
        endcase
        if (bias == 1)
            v[SAMPLE_BITS-1] = 1'b0;
        else if (bias == 2)
            v[SAMPLE_BITS-1] = 1'b1;
        return v;
    endfunction

    task automatic send_item(input logic signed [SAMPLE_BITS-1:0] s, input logic eod);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        sample      <= s;
        end_of_data <= eod;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_for_bins();
        in_valid <= 1'b0;
        while (bins_waiting != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic reconfigure(input logic [2:0] mask, input int c, input int s, input int b);
        cfg_idx_t  idx_list [3];
        cfg_data_t val_list [3];
        idx_list = '{CFG_CHANNELS, CFG_SPB, CFG_BINS};
        val_list = '{cfg_data_t'(c), cfg_data_t'(s), cfg_data_t'(b)};
        wait_for_bins();
        for (int i = 0; i < 3; i++)
        begin
            if (mask[i])
            begin
                cfg_write <= 1'b1;
                cfg_index <= idx_list[i];
                cfg_data  <= val_list[i];
                @(negedge clk);
            end
        end
        cfg_write <= 1'b0;
        if (mask[CFG_CHANNELS]) chan_now = c;
        if (mask[CFG_SPB])      spb_now  = s;
        if (mask[CFG_BINS])     bins_now = b;
        settings_used++;
    endtask

    initial
    begin
        int wait_len;
        out_ready   = 1'b0;
        hold_served = 0;
        @(negedge clk);
        forever
        begin
            if (hold_req && !hold_served)
            begin
                wait_len    = HOLD_CYCLES;
                hold_served = 1;
            end
            else
                wait_len = pick_gap(recv_calm);
            if (wait_len > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_len) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int   n;
        int   eod_odds;
        int   bias;
        int   c_new;
        int   s_new;
        int   b_new;
        logic [2:0] mask;
        bit   first_phase;
        logic eod;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        sample        = '0;
        end_of_data   = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_CHANNELS;
        cfg_data      = '0;
        send_calm     = 0;
        recv_calm     = 0;
        hold_req      = 0;
        quiet_cycles  = 0;
        settings_used = 1;
        chan_now      = int'(CH_RESET);
        spb_now       = int'(SPB_RESET);
        bins_now      = int'(BINS_RESET);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Single-channel, single-frame bins at the sample extremes.
        send_item(16'h7FFF, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h0001, 1'b0);
        send_item(16'h5555, 1'b1);

        // Zero registers act as one; one bin fills and samples up to eod are ignored.
        reconfigure(3'b111, 0, 0, 0);
        send_item(16'h1234, 1'b0);
        send_item(16'h4321, 1'b0);
        send_item(16'hAAAA, 1'b1);
        send_item(16'h00FF, 1'b0);

        // Oversized registers saturate; an early end closes a partial frame and bin.
        reconfigure(3'b111, 15, (1 << 21) - 1, 8191);
        send_item(16'h8000, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'h7FFF, 1'b1);

        // Registers changed while a frame and a bin are still open.
        reconfigure(3'b111, 3, 2, 2);
        for (int i = 0; i < 6; i++)
            send_item(pick_sample(0), 1'b0);
        send_item(16'h7000, 1'b0);
        send_item(16'h6000, 1'b0);
        reconfigure(3'b001, 2, 0, 0);
        send_item(16'h9000, 1'b0);
        reconfigure(3'b010, 0, 1, 0);
        send_item(16'hC000, 1'b0);
        send_item(16'h2222, 1'b0);
        send_item(16'h3333, 1'b1);

        // Long output stall while samples keep coming, so the input backs up.
        reconfigure(3'b111, 1, 1, 4096);
        send_calm = 1;
        hold_req  = 1;
        repeat (40) send_item(pick_sample(0), 1'b0);
        send_calm = 0;

        first_phase = 1;
        while (live_items < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0:       c_new = 0;
                1:       c_new = $urandom_range(9, 15);
                2:       c_new = MAX_CHANNELS;
                default: c_new = $urandom_range(1, MAX_CHANNELS);
            endcase
            case ($urandom_range(0, 11))
                0:       s_new = 0;
                1:       s_new = MAX_BIN_FRAMES;
                2:       s_new = $urandom_range(MAX_BIN_FRAMES + 1, (1 << SPB_W) - 1);
                3:       s_new = $urandom_range(7, 40);
                default: s_new = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 9))
                0:       b_new = 0;
                1:       b_new = $urandom_range(1, 4);
                2:       b_new = MAX_BINS;
                3:       b_new = $urandom_range(MAX_BINS + 1, (1 << BINS_W) - 1);
                default: b_new = $urandom_range(5, MAX_BINS - 1);
            endcase
            mask = first_phase ? 3'b111 : 3'($urandom_range(0, 7));
            first_phase = 0;
            reconfigure(mask, c_new, s_new, b_new);

            send_calm = ($urandom_range(0, 4) == 0);
            recv_calm = ($urandom_range(0, 4) == 0);
            bias      = $urandom_range(0, 5);
            if (spb_now > 64 || bins_now <= 4)
                eod_odds = 15;
            else if ($urandom_range(0, 3) == 0)
                eod_odds = 0;
            else
                eod_odds = 50;
            n = $urandom_range(20, 80);
            repeat (n)
            begin
                eod = (eod_odds != 0) && ($urandom_range(1, eod_odds) == 1);
                send_item(pick_sample(bias), eod);
            end
        end

        wait_for_bins();
        $display("Streamed %0d samples (%0d more ignored past the bin limit), checked %0d bins.",
                 live_items, ignored_items, bins_checked);
        $display("Register settings applied: %0d, long output stall taken: %0d.",
                 settings_used, hold_served);
        if (fail_count == 0 && bins_waiting == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
